FILE: rtl/cbpe_pkg.sv
// ---------------------------------------------------------------------------
// cbpe_pkg
// Shared types and constants for the cubic Bezier point evaluator.
// ---------------------------------------------------------------------------
package cbpe_pkg;

   // Fixed-point formats
   localparam int PARAM_W  = 17;                  // unsigned Q1.16 curve parameter
   localparam int WEIGHT_W = 18;                  // unsigned Q2.16 Bernstein weight, below 4.0
   localparam int COORD_W  = 20;                  // signed Q12.8 coordinate
   localparam int POINT_W  = 3 * COORD_W;         // packed x, y, z
   localparam int CSR_IDX_W = 2;

   localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

   typedef logic [PARAM_W-1:0]         param_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic [POINT_W-1:0]         point_type;

   // Configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POINT_A = 2'd0,
      CSR_POINT_B = 2'd1,
      CSR_POINT_C = 2'd2,
      CSR_POINT_D = 2'd3
   } csr_index_type;

   // Four Bernstein weights for one parameter value
   typedef struct packed {
      weight_type w0;
      weight_type w1;
      weight_type w2;
      weight_type w3;
   } weights_type;

endpackage

FILE: rtl/cbpe_req_if.sv
// ---------------------------------------------------------------------------
// cbpe_req_if / cbpe_rsp_if
// Valid/ready channels carrying curve parameters in and curve points out.
// ---------------------------------------------------------------------------
interface cbpe_req_if import cbpe_pkg::*; ();
   logic      valid;
   logic      ready;
   param_type param_t;

   modport source (output valid, output param_t, input ready);
   modport sink   (input valid, input param_t, output ready);
endinterface

interface cbpe_rsp_if import cbpe_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type coord_x;
   coord_type coord_y;
   coord_type coord_z;

   modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

FILE: rtl/cbpe_weight_gen.sv
// ---------------------------------------------------------------------------
// cbpe_weight_gen
// Three-stage pipeline turning a Q1.16 parameter into the four cubic
// Bernstein weights, each product floored to 16 fraction bits.
// ---------------------------------------------------------------------------
module cbpe_weight_gen import cbpe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  param_type   param_t,
   output logic        out_valid,
   input  logic        out_ready,
   output weights_type weights
);

   // Stage A: saturate t, form u = 1 - t
   logic        a_vld_ff, a_vld_in;
   param_type   a_t_ff, a_u_ff, a_t_in, a_u_in;
   // Stage B: squares
   logic        b_vld_ff, b_vld_in;
   param_type   b_t_ff, b_u_ff, b_uu_ff, b_tt_ff;
   param_type   b_uu_in, b_tt_in;
   // Stage C: cubes and cross terms
   logic        c_vld_ff, c_vld_in;
   weights_type c_w_ff, c_w_in;

   logic        a_rdy, b_rdy, c_rdy;
   logic [2*PARAM_W-1:0] sq_u, sq_t, cu_u, cu_t, x_ut, x_tu;
   logic [2*PARAM_W+1:0] tri_ut, tri_tu;

   // Per-stage ready: a stage moves when it is empty or its successor moves
   assign c_rdy    = !c_vld_ff || out_ready;
   assign b_rdy    = !b_vld_ff || c_rdy;
   assign a_rdy    = !a_vld_ff || b_rdy;
   assign in_ready = a_rdy;

   // Stage A datapath
   always_comb begin
      a_t_in = (param_t > ONE_Q16) ? ONE_Q16 : param_t;
      a_u_in = ONE_Q16 - a_t_in;
   end

   // Stage B datapath
   always_comb begin
      sq_u    = a_u_ff * a_u_ff;
      sq_t    = a_t_ff * a_t_ff;
      b_uu_in = sq_u[PARAM_W+15:16];
      b_tt_in = sq_t[PARAM_W+15:16];
   end

   // Stage C datapath: times three by shift and add
   always_comb begin
      cu_u   = b_uu_ff * b_u_ff;
      cu_t   = b_tt_ff * b_t_ff;
      x_ut   = b_uu_ff * b_t_ff;
      x_tu   = b_u_ff * b_tt_ff;
      tri_ut = {2'b00, x_ut} + {1'b0, x_ut, 1'b0};
      tri_tu = {2'b00, x_tu} + {1'b0, x_tu, 1'b0};
      c_w_in.w0 = {1'b0, cu_u[PARAM_W+15:16]};
      c_w_in.w1 = tri_ut[WEIGHT_W+15:16];
      c_w_in.w2 = tri_tu[WEIGHT_W+15:16];
      c_w_in.w3 = {1'b0, cu_t[PARAM_W+15:16]};
   end

   // Valid bits
   always_comb begin
      a_vld_in = a_rdy ? in_valid : a_vld_ff;
      b_vld_in = b_rdy ? a_vld_ff : b_vld_ff;
      c_vld_in = c_rdy ? b_vld_ff : c_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (a_rdy && in_valid) begin
         a_t_ff <= a_t_in;
         a_u_ff <= a_u_in;
      end
      if (b_rdy && a_vld_ff) begin
         b_t_ff  <= a_t_ff;
         b_u_ff  <= a_u_ff;
         b_uu_ff <= b_uu_in;
         b_tt_ff <= b_tt_in;
      end
      if (c_rdy && b_vld_ff) begin
         c_w_ff <= c_w_in;
      end
   end

   assign out_valid = c_vld_ff;
   assign weights   = c_w_ff;

endmodule

FILE: rtl/cubic_bezier_point_eval_unit.sv
// Pipeline: five register stages, three for the weights, one for products, one for the sum.
// Throughput: one request per cycle unless back-pressure stalls it; each stage holds independently.
// Reset: synchronous, active high; clears all valid bits and the four control points.
// ---------------------------------------------------------------------------
// cubic_bezier_point_eval_unit
// Evaluates a 3D cubic Bezier curve at t, with unused third and fourth
// control points replaced by their predecessors, saturating to Q12.8.
// ---------------------------------------------------------------------------
module cubic_bezier_point_eval_unit import cbpe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   cbpe_req_if.sink             req_bus,
   cbpe_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  point_type            csr_wdata
);

   localparam int PROD_W = WEIGHT_W + 1 + COORD_W;   // signed weight times coordinate
   localparam int TERM_W = PROD_W - 17;              // floored product, one guard bit dropped
   localparam int SUM_W  = TERM_W + 2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(524287);
   localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(524288);

   // Control point registers and substituted points
   point_type pt_a_ff, pt_b_ff, pt_c_ff, pt_d_ff;
   point_type eff_c_ff, eff_d_ff, eff_c_in, eff_d_in;
   point_type pts [4];

   // Weight pipeline handshake
   logic        w_valid, w_ready;
   weights_type w_bus;
   weight_type  w_arr [4];

   // Stage D: products
   logic                     d_vld_ff, d_vld_in, d_rdy;
   logic signed [TERM_W-1:0] d_term_ff [3][4];
   logic signed [TERM_W-1:0] d_term_in [3][4];
   logic signed [PROD_W-1:0] prod      [3][4];

   // Stage E: sums and saturation
   logic                     e_vld_ff, e_vld_in, e_rdy;
   coord_type                e_coord_ff [3];
   coord_type                e_coord_in [3];
   logic signed [SUM_W-1:0]  sum        [3];

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pt_a_ff <= '0;
         pt_b_ff <= '0;
         pt_c_ff <= '0;
         pt_d_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POINT_A: pt_a_ff <= csr_wdata;
            CSR_POINT_B: pt_b_ff <= csr_wdata;
            CSR_POINT_C: pt_c_ff <= csr_wdata;
            CSR_POINT_D: pt_d_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unused-point substitution, registered; the user must keep config static while requests run (not enforced)
   always_comb begin
      eff_c_in = (pt_c_ff == '0) ? pt_b_ff : pt_c_ff;
      eff_d_in = (pt_d_ff == '0) ? eff_c_in : pt_d_ff;
   end

   always_ff @(posedge clock) begin
      eff_c_ff <= eff_c_in;
      eff_d_ff <= eff_d_in;
   end

   assign pts[0] = pt_a_ff;
   assign pts[1] = pt_b_ff;
   assign pts[2] = eff_c_ff;
   assign pts[3] = eff_d_ff;

   // Bernstein weights
   cbpe_weight_gen u_weight_gen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .param_t   (req_bus.param_t),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .weights   (w_bus)
   );

   assign w_arr[0] = w_bus.w0;
   assign w_arr[1] = w_bus.w1;
   assign w_arr[2] = w_bus.w2;
   assign w_arr[3] = w_bus.w3;

   // Stage ready chain
   assign e_rdy   = !e_vld_ff || rsp_bus.ready;
   assign d_rdy   = !d_vld_ff || e_rdy;
   assign w_ready = d_rdy;

   // Stage D: weight times coordinate, floored to 8 fraction bits
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         for (int k = 0; k < 4; k++) begin
            prod[ax][k] = $signed({1'b0, w_arr[k]})
                        * $signed(pts[k][ax*COORD_W +: COORD_W]);
            d_term_in[ax][k] = $signed(prod[ax][k][PROD_W-2:16]);
         end
      end
   end

   // Stage E: four-term sum with saturation
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         sum[ax] = SUM_W'(d_term_ff[ax][0]) + SUM_W'(d_term_ff[ax][1])
                 + SUM_W'(d_term_ff[ax][2]) + SUM_W'(d_term_ff[ax][3]);
         if (sum[ax] > SUM_MAX) begin
            e_coord_in[ax] = SUM_MAX[COORD_W-1:0];
         end else if (sum[ax] < SUM_MIN) begin
            e_coord_in[ax] = SUM_MIN[COORD_W-1:0];
         end else begin
            e_coord_in[ax] = sum[ax][COORD_W-1:0];
         end
      end
   end

   // Valid bits
   always_comb begin
      d_vld_in = d_rdy ? w_valid : d_vld_ff;
      e_vld_in = e_rdy ? d_vld_ff : e_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= d_vld_in;
         e_vld_ff <= e_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (d_rdy && w_valid) begin
         d_term_ff <= d_term_in;
      end
      if (e_rdy && d_vld_ff) begin
         e_coord_ff <= e_coord_in;
      end
   end

   // Response
   assign rsp_bus.valid   = e_vld_ff;
   assign rsp_bus.coord_x = e_coord_ff[0];
   assign rsp_bus.coord_y = e_coord_ff[1];
   assign rsp_bus.coord_z = e_coord_ff[2];

endmodule

FILE: verif/tb_cubic_bezier_point_eval_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_cubic_bezier_point_eval_unit
// Drives curve parameters into the Bezier point evaluator under random
// valid/ready idling, and checks every returned x, y, z against a local
// fixed-point model of the curve built from shadow copies of the four
// control-point registers. Directed requests cover the parameter limits,
// unused third/fourth points and extreme coordinates; random curves follow.
// ---------------------------------------------------------------------------
module tb_cubic_bezier_point_eval_unit;
   import cbpe_pkg::*;

   localparam int    RESET_CYCLES   = 11;
   localparam int    DRAIN_CYCLES   = 8;
   localparam int    WATCHDOG_LIMIT = 2000;
   localparam int    RANDOM_PHASES  = 40;
   localparam int    QUIET_PHASES   = 6;
   localparam int    PRINT_LIMIT    = 100;
   localparam longint Q16_ONE       = longint'(ONE_Q16);
   localparam longint COORD_HI      = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_LO      = -(longint'(1) <<< (COORD_W - 1));
   localparam coord_type COORD_TOP    = {1'b0, {(COORD_W - 1){1'b1}}};
   localparam coord_type COORD_BOTTOM = {1'b1, {(COORD_W - 1){1'b0}}};

   // expected curve point, tagged with the parameter that produced it
   typedef struct {
      param_type param;
      coord_type x;
      coord_type y;
      coord_type z;
   } curve_point_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   point_type            csr_wdata;

   cbpe_req_if req_bus ();
   cbpe_rsp_if rsp_bus ();

   cubic_bezier_point_eval_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the control-point registers
   point_type curve_ctrl [4];

   curve_point_type expected_points [$];

   int mismatch_count = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int curve_count    = 0;
   int req_idle_pct   = 20;
   int rsp_idle_pct   = 20;
   int stall_left     = 0;
   int quiet_cycles   = 0;

   always #10 clock = ~clock;

   // -----------------------------------------------------------------------
   // Curve model
   // -----------------------------------------------------------------------
   function automatic longint coord_of(input point_type pt, input int axis);
      coord_type c;
      c = pt[axis * COORD_W +: COORD_W];
      return longint'(c);
   endfunction

   function automatic curve_point_type bezier_point(input param_type p);
      longint t, u, uu, uuu, tt, ttt, acc;
      longint w [4];
      longint c [3];
      point_type pts [4];
      curve_point_type r;
      int axis, k;
      // parameter saturates at 1.0
      t   = (p > ONE_Q16) ? Q16_ONE : longint'(p);
      u   = Q16_ONE - t;
      uu  = (u * u) >>> 16;
      uuu = (uu * u) >>> 16;
      tt  = (t * t) >>> 16;
      ttt = (tt * t) >>> 16;
      w[0] = uuu;
      w[1] = (3 * uu * t) >>> 16;
      w[2] = (3 * u * tt) >>> 16;
      w[3] = ttt;
      // an all-zero third or fourth point falls back to its predecessor
      pts[0] = curve_ctrl[CSR_POINT_A];
      pts[1] = curve_ctrl[CSR_POINT_B];
      pts[2] = (curve_ctrl[CSR_POINT_C] == '0) ? pts[1] : curve_ctrl[CSR_POINT_C];
      pts[3] = (curve_ctrl[CSR_POINT_D] == '0) ? pts[2] : curve_ctrl[CSR_POINT_D];
      for (axis = 0; axis < 3; axis++) begin
         acc = 0;
         // arithmetic shift floors each product
         for (k = 0; k < 4; k++)
            acc += (w[k] * coord_of(pts[k], axis)) >>> 16;
         if (acc > COORD_HI)
            acc = COORD_HI;
         else if (acc < COORD_LO)
            acc = COORD_LO;
         c[axis] = acc;
      end
      r.param = p;
      r.x     = coord_type'(c[0]);
      r.y     = coord_type'(c[1]);
      r.z     = coord_type'(c[2]);
      return r;
   endfunction

   // -----------------------------------------------------------------------
   // Stimulus helpers
   // -----------------------------------------------------------------------
   function automatic point_type make_point(input coord_type x, y, z);
      return {z, y, x};
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_TOP;
         1:       return COORD_BOTTOM;
         2:       return coord_type'(int'($urandom_range(0, 2047)) - 1024);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // may_skip lets a third or fourth point come out unused
   function automatic point_type random_point(input bit may_skip);
      if (may_skip && $urandom_range(0, 3) == 0)
         return '0;
      return make_point(random_coord(), random_coord(), random_coord());
   endfunction

   function automatic param_type random_param();
      case ($urandom_range(0, 9))
         0: return param_type'($urandom_range(65537, 131071));
         1: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return param_type'(1);
               2:       return param_type'(ONE_Q16 - 1);
               default: return ONE_Q16;
            endcase
         end
         default: return param_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic int idle_rate();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 25;
         default: return 50;
      endcase
   endfunction

   // one request; valid is left high so back-to-back requests need no gap
   task automatic send_param(input param_type p);
      int gap;
      if (req_idle_pct != 0 && $urandom_range(1, 100) <= req_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.param_t <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_points.push_back(bezier_point(p));
      sent_count++;
   endtask

   // stop sending and wait for the pipeline to empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all four control points, only once the block is idle
   task automatic load_curve(input point_type a, b, c, d);
      point_type     vals [4];
      csr_index_type idx  [4];
      int i;
      drain();
      vals = '{a, b, c, d};
      idx  = '{CSR_POINT_A, CSR_POINT_B, CSR_POINT_C, CSR_POINT_D};
      for (i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         curve_ctrl[idx[i]] = vals[i];
      end
      csr_we <= 1'b0;
      curve_count++;
   endtask

   task automatic note_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------
   // registers straight out of reset: every point zero
   task automatic test_reset_state();
      send_param(ONE_Q16 >> 1);
   endtask

   // parameter limits, saturation above 1.0, every bit of t both ways
   task automatic test_param_extremes();
      param_type params [9];
      int i;
      load_curve(make_point(-20'sd1000, 20'sd2000, 20'sd300),
                 make_point(20'sd150000, -20'sd77777, 20'sd4096),
                 make_point(-20'sd250000, 20'sd300000, -20'sd12345),
                 make_point(20'sd400000, 20'sd5, -20'sd400000));
      params = '{17'd0, 17'd1, 17'd21845, 17'd32768, 17'h0AAAA, 17'd65535,
                 17'd65536, 17'd65537, 17'h1FFFF};
      for (i = 0; i < 9; i++)
         send_param(params[i]);
   endtask

   // unused third point, unused fourth point, and both unused
   task automatic test_point_substitution();
      point_type pa, pb, pc, pd;
      pa = make_point(20'sd1024, -20'sd2048, 20'sd4096);
      pb = make_point(-20'sd90000, 20'sd123456, 20'sd70000);
      pc = make_point(20'sd300000, 20'sd3, -20'sd200000);
      pd = make_point(-20'sd5000, -20'sd450000, 20'sd450000);
      load_curve(pa, pb, '0, pd);
      send_param(17'd16384);
      send_param(17'd49152);
      load_curve(pa, pb, pc, '0);
      send_param(17'd16384);
      send_param(17'd49152);
      load_curve(pa, pb, '0, '0);
      send_param(17'd16384);
      send_param(17'd49152);
   endtask

   // largest, smallest and alternating coordinates, and all-ones registers
   task automatic test_coord_extremes();
      point_type top, bottom;
      top    = make_point(COORD_TOP, COORD_TOP, COORD_TOP);
      bottom = make_point(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM);
      load_curve(top, top, top, top);
      send_param(17'd32768);
      send_param(17'h1FFFF);
      load_curve(bottom, bottom, bottom, bottom);
      send_param(17'd32768);
      send_param(17'd1);
      load_curve(top, bottom, top, bottom);
      send_param(17'd32768);
      send_param(17'd10000);
      load_curve('1, '1, '1, '1);
      send_param(17'd32768);
      send_param(17'd60000);
   endtask

   // random curves, each followed by a full drain; the final phases run flat out
   task automatic test_random_curves();
      int phase, n_items;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_curve(random_point(1'b0), random_point(1'b0),
                    random_point(1'b1), random_point(1'b1));
         if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = idle_rate();
            rsp_idle_pct = idle_rate();
         end
         n_items = $urandom_range(30, 52);
         repeat (n_items) send_param(random_param());
      end
   endtask

   // -----------------------------------------------------------------------
   // Result side: back-pressure in random bursts
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left = stall_left - 1;
      else if (rsp_idle_pct != 0 && $urandom_range(1, 100) <= rsp_idle_pct)
         stall_left = $urandom_range(1, 6);
      rsp_bus.ready <= (stall_left == 0);
   end

   // compare each returned point with the oldest expectation
   always @(posedge clock) begin
      curve_point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            note_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                    rsp_bus.coord_x, rsp_bus.coord_y, rsp_bus.coord_z));
         end else begin
            want = expected_points.pop_front();
            checked_count++;
            if (rsp_bus.coord_x !== want.x)
               note_mismatch($sformatf("t=%0d coord_x got %0d want %0d",
                                       want.param, rsp_bus.coord_x, want.x));
            if (rsp_bus.coord_y !== want.y)
               note_mismatch($sformatf("t=%0d coord_y got %0d want %0d",
                                       want.param, rsp_bus.coord_y, want.y));
            if (rsp_bus.coord_z !== want.z)
               note_mismatch($sformatf("t=%0d coord_z got %0d want %0d",
                                       want.param, rsp_bus.coord_z, want.z));
         end
      end
   end

   // watchdog: too long without any request, point or register write
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles, %0d points outstanding",
                  quiet_cycles, expected_points.size());
         $display("tb_cubic_bezier_point_eval_unit: FAIL");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Sequence
   // -----------------------------------------------------------------------
   initial begin
      int i;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_POINT_A;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.param_t <= '0;
      for (i = 0; i < 4; i++)
         curve_ctrl[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_param_extremes();
      test_point_substitution();
      test_coord_extremes();
      test_random_curves();
      drain();

      $display("Covered %0d requests across %0d control-point settings,", sent_count,
               curve_count);
      $display("%0d curve points compared, %0d mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_cubic_bezier_point_eval_unit: PASS");
      else
         $display("tb_cubic_bezier_point_eval_unit: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/cbpe_pkg.sv
rtl/cbpe_req_if.sv
rtl/cbpe_weight_gen.sv
rtl/cubic_bezier_point_eval_unit.sv
verif/tb_cubic_bezier_point_eval_unit.sv
